/* sv/aenc_pkg.sv */
// shared types, byte and code point constants for the archive entry name checker
package aenc_pkg;

	localparam logic [7:0] BYTE_NUL       = 8'h00;
	localparam logic [7:0] BYTE_SPACE     = 8'h20;
	localparam logic [7:0] BYTE_DOT       = 8'h2e;
	localparam logic [7:0] BYTE_SLASH     = 8'h2f;
	localparam logic [7:0] BYTE_COLON     = 8'h3a;
	localparam logic [7:0] BYTE_BACKSLASH = 8'h5c;
	localparam logic [7:0] BYTE_DEL       = 8'h7f;
	localparam logic [7:0] LEAD2_LO       = 8'hc2;
	localparam logic [7:0] LEAD2_HI       = 8'hdf;
	localparam logic [7:0] LEAD3_LO       = 8'he0;
	localparam logic [7:0] LEAD3_HI       = 8'hef;
	localparam logic [7:0] LEAD4_LO       = 8'hf0;
	localparam logic [7:0] LEAD4_HI       = 8'hf4;

	localparam logic [1:0] CLS_TWO   = 2'd2;
	localparam logic [1:0] CLS_THREE = 2'd3;

	localparam logic [20:0] CP_MIN_3      = 21'h000800;
	localparam logic [20:0] CP_MIN_4      = 21'h010000;
	localparam logic [20:0] CP_SURR_LO    = 21'h00d800;
	localparam logic [20:0] CP_SURR_HI    = 21'h00dfff;
	localparam logic [20:0] CP_MAX        = 21'h10ffff;

	typedef struct packed {
		logic [1:0]  pend;
		logic [1:0]  cls;
		logic [20:0] acc;
	} utf8_st_t;

	typedef struct packed {
		logic seg_start;
		logic only_dots;
	} path_st_t;

	localparam utf8_st_t UTF8_RESET = '{pend: 2'd0, cls: 2'd0, acc: 21'd0};
	localparam path_st_t PATH_RESET = '{seg_start: 1'b1, only_dots: 1'b0};

endpackage

/* sv/aenc_utf8_step.sv */
// one utf-8 decoding step: next decoder state and encoding error for a byte
module aenc_utf8_step import aenc_pkg::*; (
	input  logic [7:0] name_byte,
	input  utf8_st_t   cur,
	output utf8_st_t   nxt,
	output logic       err
);

	logic [1:0]  pend_dec;
	logic [20:0] acc_shift;

	assign pend_dec  = cur.pend - 2'd1;
	assign acc_shift = {cur.acc[14:0], name_byte[5:0]};

	always_comb begin
		nxt = cur;
		err = 1'b0;
		if (cur.pend != 2'd0) begin
			if (name_byte[7:6] != 2'b10) begin
				nxt.pend = 2'd0;
				err      = 1'b1;
			end else begin
				nxt.acc  = acc_shift;
				nxt.pend = pend_dec;
				if (pend_dec == 2'd0) begin
					nxt.cls = 2'd0;
					// overlong, surrogate and out of range checks
					if ((cur.cls == CLS_TWO && acc_shift < CP_MIN_3) ||
					    (cur.cls == CLS_THREE && acc_shift < CP_MIN_4) ||
					    (acc_shift >= CP_SURR_LO && acc_shift <= CP_SURR_HI) ||
					    acc_shift > CP_MAX)
						err = 1'b1;
				end
			end
		end else if (name_byte == BYTE_NUL) begin
			err = 1'b1;
		end else if (name_byte[7] == 1'b0) begin
			err = 1'b0;
		end else if (name_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
			nxt.pend = 2'd1;
			nxt.cls  = 2'd1;
			nxt.acc  = {16'd0, name_byte[4:0]};
		end else if (name_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
			nxt.pend = 2'd2;
			nxt.cls  = 2'd2;
			nxt.acc  = {17'd0, name_byte[3:0]};
		end else if (name_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
			nxt.pend = 2'd3;
			nxt.cls  = 2'd3;
			nxt.acc  = {18'd0, name_byte[2:0]};
		end else begin
			err = 1'b1;
		end
	end

endmodule

/* sv/aenc_path_step.sv */
// one path rule step: segment tracking and forbidden byte checks
module aenc_path_step import aenc_pkg::*; (
	input  logic [7:0] name_byte,
	input  path_st_t   cur,
	output path_st_t   nxt,
	output logic       err
);

	logic is_dot;

	assign is_dot = (name_byte == BYTE_DOT);

	always_comb begin
		nxt = cur;
		err = 1'b0;
		if (name_byte < BYTE_SPACE || name_byte == BYTE_DEL ||
		    name_byte == BYTE_BACKSLASH || name_byte == BYTE_COLON) begin
			err = 1'b1;
		end else if (name_byte == BYTE_SLASH) begin
			// no leading, doubled or dot-segment slash
			err           = cur.seg_start | cur.only_dots;
			nxt.seg_start = 1'b1;
			nxt.only_dots = 1'b0;
		end else begin
			nxt.only_dots = cur.seg_start ? is_dot : (cur.only_dots & is_dot);
			nxt.seg_start = 1'b0;
		end
	end

endmodule

/* sv/archive_entry_name_checker.sv */
// top level of the archive entry name checker
//
// usage: feed the bytes of one archive entry name on the s_axis channel, one
// byte per transaction, with s_axis_tlast high on the final byte. the name is
// checked for strict utf-8, forbidden bytes (controls, del, backslash, colon),
// slash placement, dot-only segments and length. one m_axis transaction with
// m_axis_tdata[0] = accepted follows each final byte; other bytes give none.
//
// throughput: one byte per cycle, unless a final byte waits for the result
// register; the name state update after the input register is combinational.
// result path: a final byte's transaction goes into the input register, then
// is decoded into the result register.
//
// reset: arst_n clears the input stage, the result register and all name
// state, so the next byte starts a fresh name; state also clears after
// every final byte.
// stall: bytes that end no name keep flowing while a result waits; a final
// byte waits in the input register until the result register is free, and
// s_axis_tready drops only then.
module archive_entry_name_checker import aenc_pkg::*; #(
	parameter int MAX_NAME_BYTES = 65535
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] name_byte
	input  logic       s_axis_tlast,  // last_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // [0] accepted, [7:1] zero
);

	// counter saturates one above the limit
	localparam int CNT_W = $clog2(MAX_NAME_BYTES + 2);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NAME_BYTES);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// name state
	utf8_st_t         utf8_q;
	path_st_t         path_q;
	logic             rej_q;
	logic [CNT_W-1:0] cnt_q;

	// result register
	logic out_valid_q;
	logic out_accepted_q;

	utf8_st_t         utf8_n;
	path_st_t         path_n;
	logic             utf8_err;
	logic             path_err;
	logic [CNT_W-1:0] cnt_n;
	logic             rej_n;
	logic             ok_n;
	logic             out_free;
	logic             adv;
	logic             s_acc;

	aenc_utf8_step u_utf8 (
		.name_byte (byte_s1),
		.cur       (utf8_q),
		.nxt       (utf8_n),
		.err       (utf8_err)
	);

	aenc_path_step u_path (
		.name_byte (byte_s1),
		.cur       (path_q),
		.nxt       (path_n),
		.err       (path_err)
	);

	assign cnt_n = (cnt_q <= CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
	assign rej_n = rej_q | (cnt_n > CNT_MAX) | utf8_err | path_err;
	// a dot-only final segment is refused; a trailing slash is fine
	assign ok_n  = ~rej_n & (utf8_n.pend == 2'd0) &
	               ~(~path_n.seg_start & path_n.only_dots);

	// only a final byte needs room in the result register
	assign out_free      = ~out_valid_q | m_axis_tready;
	assign adv           = valid_s1 & (~last_s1 | out_free);
	assign s_axis_tready = ~valid_s1 | adv;
	assign s_acc         = s_axis_tvalid & s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_accepted_q};

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// name state update, cleared after each final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf8_q <= UTF8_RESET;
			path_q <= PATH_RESET;
			rej_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (adv) begin
			if (last_s1) begin
				utf8_q <= UTF8_RESET;
				path_q <= PATH_RESET;
				rej_q  <= 1'b0;
				cnt_q  <= '0;
			end else begin
				utf8_q <= utf8_n;
				path_q <= path_n;
				rej_q  <= rej_n;
				cnt_q  <= cnt_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_accepted_q <= ok_n;
		end
	end

endmodule

/* sv/aenc_checker.sv */
// port-level checks for the archive entry name checker, bound to the top level
module aenc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       s_axis_tlast,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	// a pending result stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a fresh result follows a final byte via the input and result registers
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |->
			$past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
		else $error("result without a final byte");

	// with the result register empty, input is never blocked
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result register");

endmodule

bind archive_entry_name_checker aenc_checker u_aenc_checker (.*);

/* bench/testbench.sv */
// self-checking bench for the archive entry name checker
`timescale 1ns / 100ps

module testbench;
	import aenc_pkg::*;

	localparam int NAME_MAX = 65535;

	// where the verdict of a name comes from: the name predictor, or typed in the table
	typedef enum logic [1:0] {SRC_MODEL, SRC_PASS, SRC_FAIL} verdict_src_t;

	typedef struct packed {
		logic [7:0]   b;
		logic         l;
		verdict_src_t src;
	} row_t;

	// directed names, one byte per row; typed verdicts only where obvious
	localparam row_t DIRECTED_ROWS [25] = '{
		// single-byte name
		'{8'h61, 1'b1, SRC_PASS},
		// nul and 0xff on their own
		'{BYTE_NUL, 1'b1, SRC_FAIL},
		'{8'hff, 1'b1, SRC_FAIL},
		// stray continuation, a clean byte after it cannot clear the error
		'{8'h80, 1'b0, SRC_MODEL}, '{8'h61, 1'b1, SRC_FAIL},
		// broken sequence
		'{LEAD2_LO + 8'h01, 1'b0, SRC_MODEL}, '{8'h41, 1'b1, SRC_FAIL},
		// truncated sequence at the end of the name
		'{8'he2, 1'b0, SRC_MODEL}, '{8'h82, 1'b1, SRC_FAIL},
		// leading slash
		'{BYTE_SLASH, 1'b0, SRC_MODEL}, '{8'h61, 1'b1, SRC_FAIL},
		// two-byte char, trailing slash is fine
		'{8'hc3, 1'b0, SRC_MODEL}, '{8'ha9, 1'b0, SRC_MODEL}, '{BYTE_SLASH, 1'b1, SRC_PASS},
		// dot-only segment before a slash
		'{BYTE_DOT, 1'b0, SRC_MODEL}, '{BYTE_DOT, 1'b0, SRC_MODEL},
		'{BYTE_SLASH, 1'b0, SRC_MODEL}, '{8'h61, 1'b1, SRC_FAIL},
		// final segment made only of dots
		'{8'h61, 1'b0, SRC_MODEL}, '{BYTE_SLASH, 1'b0, SRC_MODEL}, '{BYTE_DOT, 1'b1, SRC_FAIL},
		// highest code point
		'{LEAD4_HI, 1'b0, SRC_MODEL}, '{8'h8f, 1'b0, SRC_MODEL},
		'{8'hbf, 1'b0, SRC_MODEL}, '{8'hbf, 1'b1, SRC_PASS}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;   // [7:0] name_byte
	logic       s_axis_tlast;   // last_byte
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;   // [0] accepted, [7:1] zero

	// predictor copy of the per-name state
	logic [1:0]  name_pend;
	logic [1:0]  name_cls;
	logic [20:0] name_cp;
	logic        seg_start;
	logic        seg_dots;
	logic        name_bad;
	logic [16:0] name_len;

	logic        verdicts [$];   // accept/reject verdicts still owed by the block
	logic [7:0]  name_q [$];     // bytes of the name being built
	int          errors = 0;
	int          results_seen = 0;
	int          rand_bytes = 0;
	bit          quiet = 1'b0;   // no idling on either side

	archive_entry_name_checker #(
		.MAX_NAME_BYTES(NAME_MAX)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t MISMATCH result %0d: %s", $time, results_seen, msg);
		errors++;
	endtask

	function automatic void clear_name_state();
		name_pend = 2'd0;
		name_cls  = 2'd0;
		name_cp   = 21'd0;
		seg_start = 1'b1;
		seg_dots  = 1'b0;
		name_bad  = 1'b0;
		name_len  = 17'd0;
	endfunction

	// advance the name state by one byte; the return value is the verdict when l is set
	function automatic logic judge_byte(input logic [7:0] b, input logic l);
		logic ok;
		// length counter saturates one past the limit
		if (name_len <= 17'(NAME_MAX))
			name_len++;
		if (name_len > 17'(NAME_MAX))
			name_bad = 1'b1;

		// utf-8 decoding
		if (name_pend != 2'd0) begin
			if (b[7:6] != 2'b10) begin
				name_pend = 2'd0;
				name_bad  = 1'b1;
			end else begin
				name_cp = {name_cp[14:0], b[5:0]};
				name_pend--;
				if (name_pend == 2'd0) begin
					// overlong, surrogate or beyond the unicode range
					if ((name_cls == CLS_TWO && name_cp < CP_MIN_3) ||
					    (name_cls == CLS_THREE && name_cp < CP_MIN_4) ||
					    (name_cp >= CP_SURR_LO && name_cp <= CP_SURR_HI) ||
					    name_cp > CP_MAX)
						name_bad = 1'b1;
					name_cls = 2'd0;
				end
			end
		end else if (b == BYTE_NUL) begin
			name_bad = 1'b1;
		end else if (!b[7]) begin
			// plain ascii, nothing to track
		end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			name_pend = 2'd1;
			name_cls  = 2'd1;
			name_cp   = 21'(b[4:0]);
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			name_pend = 2'd2;
			name_cls  = 2'd2;
			name_cp   = 21'(b[3:0]);
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			name_pend = 2'd3;
			name_cls  = 2'd3;
			name_cp   = 21'(b[2:0]);
		end else begin
			name_bad = 1'b1;
		end

		// path rules
		if (b < BYTE_SPACE || b == BYTE_DEL || b == BYTE_BACKSLASH || b == BYTE_COLON) begin
			name_bad = 1'b1;
		end else if (b == BYTE_SLASH) begin
			if (seg_start || seg_dots)
				name_bad = 1'b1;
			seg_start = 1'b1;
			seg_dots  = 1'b0;
		end else begin
			seg_dots  = seg_start ? (b == BYTE_DOT) : (seg_dots && b == BYTE_DOT);
			seg_start = 1'b0;
		end

		ok = !name_bad && name_pend == 2'd0 && !(!seg_start && seg_dots);
		if (l)
			clear_name_state();
		return ok;
	endfunction

	// append cp encoded in nb bytes, overlong forms included
	function automatic void push_utf8(input logic [20:0] cp, input int nb);
		case (nb)
			1: name_q.push_back({1'b0, cp[6:0]});
			2: begin
				name_q.push_back({3'b110, cp[10:6]});
				name_q.push_back({2'b10, cp[5:0]});
			end
			3: begin
				name_q.push_back({4'b1110, cp[15:12]});
				name_q.push_back({2'b10, cp[11:6]});
				name_q.push_back({2'b10, cp[5:0]});
			end
			default: begin
				name_q.push_back({5'b11110, cp[20:18]});
				name_q.push_back({2'b10, cp[17:12]});
				name_q.push_back({2'b10, cp[11:6]});
				name_q.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// one character of a segment, mostly well-formed
	function automatic void add_unit();
		int          k;
		int          nb;
		logic [20:0] cp;
		k = $urandom_range(0, 39);
		if (k < 14) begin
			name_q.push_back(8'($urandom_range(32, 126)));
		end else if (k < 16) begin
			name_q.push_back(BYTE_DOT);
		end else if (k < 20) begin
			push_utf8(21'($urandom_range(32'h80, 32'h7ff)), 2);
		end else if (k < 24) begin
			push_utf8(21'($urandom_range(32'h800, 32'hffff)), 3);
		end else if (k < 27) begin
			push_utf8(21'($urandom_range(32'h10000, 32'h10ffff)), 4);
		end else if (k < 31) begin
			// code points on the edges of the encoding ranges
			case ($urandom_range(0, 9))
				0: cp = 21'h80;
				1: cp = 21'h7ff;
				2: cp = CP_MIN_3;
				3: cp = 21'hffff;
				4: cp = CP_SURR_LO - 21'd1;
				5: cp = CP_SURR_LO;
				6: cp = CP_SURR_HI;
				7: cp = CP_SURR_HI + 21'd1;
				8: cp = CP_MIN_4;
				default: cp = CP_MAX;
			endcase
			nb = (cp < CP_MIN_3) ? 2 : (cp < CP_MIN_4) ? 3 : 4;
			push_utf8(cp, nb);
		end else if (k < 33) begin
			// overlong form
			nb = $urandom_range(2, 4);
			cp = (nb == 2) ? 21'($urandom_range(0, 32'h7f)) :
			     (nb == 3) ? 21'($urandom_range(0, 32'h7ff)) :
			                 21'($urandom_range(0, 32'hffff));
			push_utf8(cp, nb);
		end else if (k < 34) begin
			// four-byte form past the top of unicode
			push_utf8(21'($urandom_range(32'h110000, 32'h1fffff)), 4);
		end else if (k < 36) begin
			// sequence cut short
			nb = $urandom_range(2, 4);
			cp = (nb == 2) ? 21'h0e9 : (nb == 3) ? 21'h20ac : 21'h1f600;
			push_utf8(cp, nb);
			repeat ($urandom_range(1, nb - 1))
				void'(name_q.pop_back());
		end else if (k < 37) begin
			name_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
		end else begin
			name_q.push_back(8'($urandom()));
		end
	endfunction

	// random name: segments joined by slashes, with some broken placements
	function automatic void make_name();
		int segs;
		name_q.delete();
		if ($urandom_range(0, 15) == 0)
			name_q.push_back(BYTE_SLASH);
		segs = $urandom_range(1, 3);
		for (int s = 0; s < segs; s++) begin
			if ($urandom_range(0, 11) == 0) begin
				repeat ($urandom_range(1, 3))
					name_q.push_back(BYTE_DOT);
			end else if ($urandom_range(0, 19) != 0) begin
				repeat ($urandom_range(1, 5))
					add_unit();
			end
			if (s < segs - 1)
				name_q.push_back(BYTE_SLASH);
		end
		if ($urandom_range(0, 5) == 0)
			name_q.push_back(BYTE_SLASH);
		if (name_q.size() == 0)
			add_unit();
	endfunction

	// drive one byte, wait for its transaction, then predict
	task automatic send_byte(input logic [7:0] b, input logic l, input verdict_src_t src);
		logic v;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= l;
		do @(posedge clk); while (!s_axis_tready);
		v = judge_byte(b, l);
		if (l)
			verdicts.push_back(src == SRC_MODEL ? v : (src == SRC_PASS));
	endtask

	task automatic send_name(input verdict_src_t src);
		foreach (name_q[i])
			send_byte(name_q[i], i == name_q.size() - 1, src);
	endtask

	// result side: ready in random stretches with stall bursts between them
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

	// compare every result transaction with the oldest owed verdict
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (verdicts.size() == 0)
				report_mismatch("result with no name pending");
			else if (m_axis_tdata !== {7'd0, verdicts[0]})
				report_mismatch($sformatf("accepted got %h want %b", m_axis_tdata, verdicts[0]));
			if (verdicts.size() != 0)
				void'(verdicts.pop_front());
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		s_axis_tlast  = 1'b0;
		clear_name_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].l, DIRECTED_ROWS[i].src);

		// random names; the tail runs without idling
		while (rand_bytes < 625) begin
			quiet = rand_bytes > 540;
			make_name();
			rand_bytes += name_q.size();
			send_name(SRC_MODEL);
		end
		s_axis_tvalid <= 1'b0;
		s_axis_tlast  <= 1'b0;

		while (verdicts.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
